// ----- sv/msp_pkg.sv -----
// Shared types and constants for the geared motor speed controller.
// Holds mode, event and sequencer codes, register indexes and reset values.
// No dependencies.
package msp_pkg;

  // Default parameter values
  localparam int STALL_LIMIT_DEF = 25;
  localparam int DUTY_MAX_DEF    = 1023;

  // Fixed limits of the bridge output
  localparam int LEG_MAX        = 1023;
  localparam int MIN_DUTY_FLOOR = 25;    // Q.8, a tenth of one duty step

  // Item kinds carried in tuser
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_CMD  = 1'b1;

  typedef enum logic [1:0] {
    RUN_STOP    = 2'd0,
    RUN_DRIVE   = 2'd1,
    RUN_BACKOFF = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_TRIP     = 2'd1,
    EV_REV_DONE = 2'd2,
    EV_STALL    = 2'd3
  } evt_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_TGT,
    ST_ERR,
    ST_INT,
    ST_PROP,
    ST_FIN,
    ST_DRV,
    ST_OUT
  } state_t;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_RPM_PER_COUNT = 3'd0;
  localparam logic [2:0] REG_GEAR_DIV      = 3'd1;
  localparam logic [2:0] REG_FF_GAIN       = 3'd2;
  localparam logic [2:0] REG_PROP_GAIN     = 3'd3;
  localparam logic [2:0] REG_INTEG_GAIN_DT = 3'd4;
  localparam logic [2:0] REG_INTEG_CLAMP   = 3'd5;
  localparam logic [2:0] REG_CURRENT_LIMIT = 3'd6;
  localparam logic [2:0] REG_MIN_DUTY      = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_RPM_PER_COUNT = 16'd12000;
  localparam logic [9:0]  RST_GEAR_DIV      = 10'd131;
  localparam logic [15:0] RST_FF_GAIN       = 16'd14899;
  localparam logic [15:0] RST_PROP_GAIN     = 16'd6554;
  localparam logic [15:0] RST_INTEG_GAIN_DT = 16'd655;
  localparam logic [17:0] RST_INTEG_CLAMP   = 18'd130944;
  localparam logic [14:0] RST_CURRENT_LIMIT = 15'd3500;
  localparam logic [9:0]  RST_MIN_DUTY      = 10'd150;

endpackage

// ----- sv/motor_speed_pi_autoreverse.sv -----
// Speed controller for a geared DC motor: feedforward plus PI with integral
// clamp, minimum duty, H-bridge leg steering, overcurrent auto-reverse, stall stop.
// Depends on msp_pkg.
//
// Usage:
//   s_axis carries one item per handshake: a speed command (tuser action = 1)
//   or a control tick (action = 0) with encoder delta and current sample.
//   m_axis returns exactly one result item per input item: both leg duties,
//   run mode, drive enable and an event code.
//   The APB port writes and reads the eight gain and limit registers; write
//   them only while no item is in flight.
// Sequencing:
//   A tick runs through one shared 34x17 multiplier five times under the
//   sequencer in PRE, TGT, ERR, INT and PROP, then passes FIN and DRV; its
//   result is registered from OUT, and the next item is taken only once the
//   sequencer is back in IDLE. Commands, ticks while disabled and ticks that
//   end a reverse go from PRE straight to OUT. The multiplier chain (measured
//   rpm, target, feedforward, integral, proportional products) lengthens a tick.
// Reset and stall:
//   rst (synchronous) restores register defaults, idles the drive and drops
//   any pending result. A result waits in the output register while the
//   receiver stalls; the next item is still taken, and its result holds in
//   the last sequencer step until the output register is free.
module motor_speed_pi_autoreverse #(
  parameter int STALL_LIMIT = msp_pkg::STALL_LIMIT_DEF,
  parameter int DUTY_MAX    = msp_pkg::DUTY_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] encoder_delta, [31:16] current_raw, [47:32] shaft_speed
  input  logic [47:0] s_axis_tdata,
  // [0] action, [1] current_valid
  input  logic [1:0]  s_axis_tuser,
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [9:0] duty_a, [19:10] duty_b, [21:20] run_mode, [22] drive_on,
  // [24:23] event_code, [31:25] zero
  output logic [31:0] m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CAP   = DUTY_MAX * 256;
  localparam int CAP_W = $clog2(CAP + 1);
  localparam int MAG_W = (CAP_W > 18) ? CAP_W : 18;
  localparam int SW    = CAP_W + 3;
  localparam int DW    = MAG_W - 7;
  localparam int STW   = $clog2(STALL_LIMIT + 2);

  // configuration registers
  logic [15:0] rpm_per_count;
  logic [9:0]  gear_div;
  logic [15:0] ff_gain;
  logic [15:0] prop_gain;
  logic [15:0] integ_gain_dt;
  logic [17:0] integ_clamp;
  logic [14:0] current_limit;
  logic [9:0]  min_duty;

  // controller state
  msp_pkg::state_t     state, state_next;
  msp_pkg::mode_t      mode;
  logic                enable;
  logic signed [15:0]  target_reg;
  logic signed [18:0]  integral;
  logic [15:0]         move_cnt;
  logic [15:0]         move_len;
  logic [15:0]         rev_cnt;
  logic [STW-1:0]      stall;
  logic [15:0]         latest_current;
  logic [9:0]          duty_a_reg;
  logic [9:0]          duty_b_reg;

  // latched item and datapath
  logic                action_in;
  logic signed [15:0]  delta_in;
  logic signed [15:0]  cur_raw_in;
  logic                cur_valid_in;
  logic signed [15:0]  target_in;
  logic signed [33:0]  mul_a;
  logic signed [16:0]  mul_b;
  logic signed [50:0]  prod;
  logic signed [31:0]  meas;
  logic signed [32:0]  err;
  logic signed [35:0]  ctl;
  msp_pkg::evt_t       event_r;

  // output register
  logic                out_valid;
  logic [9:0]          out_duty_a;
  logic [9:0]          out_duty_b;
  logic [1:0]          out_mode;
  logic                out_enable;
  logic [1:0]          out_event;

  // combinational helpers
  logic                in_fire;
  logic                cfg_we;
  logic                out_free;
  logic [15:0]         cur_abs;
  logic [15:0]         cur_new;
  logic [15:0]         move_inc;
  logic [15:0]         rev_inc;
  logic                trip;
  logic                rev_done;
  logic signed [15:0]  tgt_neg;
  msp_pkg::evt_t       pre_event;
  logic signed [34:0]  sh;
  logic signed [32:0]  err_next;
  logic signed [35:0]  isum;
  logic signed [35:0]  lim36;
  logic signed [18:0]  acc_c;
  logic signed [35:0]  fsum;
  logic signed [35:0]  cap36;
  logic signed [35:0]  ctl_clamp;
  logic signed [35:0]  ctl_abs;
  logic [CAP_W-1:0]    mag;
  logic                stall_cond;
  logic [STW-1:0]      stall_inc;
  logic                stall_stop;
  logic [MAG_W-1:0]    mag_ext;
  logic [MAG_W-1:0]    md_q8;
  logic [MAG_W-1:0]    m1;
  logic [MAG_W-1:0]    m2;
  logic [MAG_W:0]      rnd;
  logic [DW-1:0]       duty_full;
  logic [9:0]          duty;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == msp_pkg::ST_IDLE);
  assign cfg_we        = psel && penable && pwrite && pready;
  assign pready        = 1'b1;
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_event, out_enable, out_mode, out_duty_b, out_duty_a};

  // register read mux
  always_comb begin
    unique case (paddr[4:2])
      msp_pkg::REG_RPM_PER_COUNT: prdata = {16'd0, rpm_per_count};
      msp_pkg::REG_GEAR_DIV:      prdata = {22'd0, gear_div};
      msp_pkg::REG_FF_GAIN:       prdata = {16'd0, ff_gain};
      msp_pkg::REG_PROP_GAIN:     prdata = {16'd0, prop_gain};
      msp_pkg::REG_INTEG_GAIN_DT: prdata = {16'd0, integ_gain_dt};
      msp_pkg::REG_INTEG_CLAMP:   prdata = {14'd0, integ_clamp};
      msp_pkg::REG_CURRENT_LIMIT: prdata = {17'd0, current_limit};
      msp_pkg::REG_MIN_DUTY:      prdata = {22'd0, min_duty};
    endcase
  end

  // tick pre-step: current sample, counters, trip and reverse checks
  always_comb begin
    cur_abs  = cur_raw_in[15] ? 16'(-cur_raw_in) : cur_raw_in;
    cur_new  = cur_valid_in ? cur_abs : latest_current;
    move_inc = (move_cnt == 16'hFFFF) ? move_cnt : move_cnt + 16'd1;
    rev_inc  = (rev_cnt == 16'hFFFF) ? rev_cnt : rev_cnt + 16'd1;
    trip     = cur_new > {1'b0, current_limit};
    rev_done = rev_inc >= move_len;
    tgt_neg  = (target_reg == 16'sh8000) ? 16'sh7FFF : -target_reg;
    pre_event = msp_pkg::EV_NONE;
    if (action_in == msp_pkg::ACT_TICK && enable) begin
      if (mode == msp_pkg::RUN_DRIVE && trip) begin
        pre_event = msp_pkg::EV_TRIP;
      end else if (mode == msp_pkg::RUN_BACKOFF && rev_done) begin
        pre_event = msp_pkg::EV_REV_DONE;
      end
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      msp_pkg::ST_PRE: begin
        mul_a = {{18{delta_in[15]}}, delta_in};
        mul_b = {1'b0, rpm_per_count};
      end
      msp_pkg::ST_TGT: begin
        mul_a = {{18{target_reg[15]}}, target_reg};
        mul_b = {7'd0, gear_div};
      end
      msp_pkg::ST_ERR: begin
        mul_a = {{8{prod[25]}}, prod[25:0]};
        mul_b = {1'b0, ff_gain};
      end
      msp_pkg::ST_INT: begin
        mul_a = {err[32], err};
        mul_b = {1'b0, integ_gain_dt};
      end
      msp_pkg::ST_PROP: begin
        mul_a = {err[32], err};
        mul_b = {1'b0, prop_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // control law arithmetic around the product register
  always_comb begin
    sh       = prod[50:16];
    err_next = {{7{prod[25]}}, prod[25:0]} - {meas[31], meas};
    // integral with clamp
    isum  = {{17{integral[18]}}, integral} + {sh[34], sh};
    lim36 = {18'd0, integ_clamp};
    if (isum > lim36) begin
      acc_c = lim36[18:0];
    end else if (isum < -lim36) begin
      acc_c = 19'(-lim36);
    end else begin
      acc_c = isum[18:0];
    end
    // output clamp
    fsum  = ctl + {sh[34], sh};
    cap36 = 36'(CAP);
    if (fsum > cap36) begin
      ctl_clamp = cap36;
    end else if (fsum < -cap36) begin
      ctl_clamp = -cap36;
    end else begin
      ctl_clamp = fsum;
    end
    // stall detection
    ctl_abs    = ctl[35] ? -ctl : ctl;
    mag        = ctl_abs[CAP_W-1:0];
    stall_cond = (SW'(mag) * SW'(5) > SW'(CAP)) && (meas > -32'sd256) && (meas < 32'sd256);
    stall_inc  = (stall > STW'(STALL_LIMIT)) ? stall : stall + STW'(1);
    stall_stop = stall_inc > STW'(STALL_LIMIT);
    // minimum duty, cap and rounding
    mag_ext = MAG_W'(mag);
    md_q8   = MAG_W'({min_duty, 8'd0});
    m1      = (mag_ext > MAG_W'(msp_pkg::MIN_DUTY_FLOOR) && mag_ext < md_q8) ? md_q8 : mag_ext;
    m2      = (m1 > MAG_W'(CAP)) ? MAG_W'(CAP) : m1;
    rnd     = {1'b0, m2} + (MAG_W + 1)'(128);
    duty_full = rnd[MAG_W:8];
    duty    = (duty_full > DW'(msp_pkg::LEG_MAX)) ? 10'(msp_pkg::LEG_MAX) : duty_full[9:0];
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      msp_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = msp_pkg::ST_PRE;
        end
      end
      msp_pkg::ST_PRE: begin
        if (action_in == msp_pkg::ACT_CMD || !enable ||
            (mode == msp_pkg::RUN_BACKOFF && rev_done)) begin
          state_next = msp_pkg::ST_OUT;
        end else begin
          state_next = msp_pkg::ST_TGT;
        end
      end
      msp_pkg::ST_TGT:  state_next = msp_pkg::ST_ERR;
      msp_pkg::ST_ERR:  state_next = msp_pkg::ST_INT;
      msp_pkg::ST_INT:  state_next = msp_pkg::ST_PROP;
      msp_pkg::ST_PROP: state_next = msp_pkg::ST_FIN;
      msp_pkg::ST_FIN:  state_next = msp_pkg::ST_DRV;
      msp_pkg::ST_DRV:  state_next = msp_pkg::ST_OUT;
      msp_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = msp_pkg::ST_IDLE;
        end
      end
      default: state_next = msp_pkg::ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rpm_per_count <= msp_pkg::RST_RPM_PER_COUNT;
      gear_div      <= msp_pkg::RST_GEAR_DIV;
      ff_gain       <= msp_pkg::RST_FF_GAIN;
      prop_gain     <= msp_pkg::RST_PROP_GAIN;
      integ_gain_dt <= msp_pkg::RST_INTEG_GAIN_DT;
      integ_clamp   <= msp_pkg::RST_INTEG_CLAMP;
      current_limit <= msp_pkg::RST_CURRENT_LIMIT;
      min_duty      <= msp_pkg::RST_MIN_DUTY;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        msp_pkg::REG_RPM_PER_COUNT: rpm_per_count <= pwdata[15:0];
        msp_pkg::REG_GEAR_DIV:      gear_div      <= pwdata[9:0];
        msp_pkg::REG_FF_GAIN:       ff_gain       <= pwdata[15:0];
        msp_pkg::REG_PROP_GAIN:     prop_gain     <= pwdata[15:0];
        msp_pkg::REG_INTEG_GAIN_DT: integ_gain_dt <= pwdata[15:0];
        msp_pkg::REG_INTEG_CLAMP:   integ_clamp   <= pwdata[17:0];
        msp_pkg::REG_CURRENT_LIMIT: current_limit <= pwdata[14:0];
        msp_pkg::REG_MIN_DUTY:      min_duty      <= pwdata[9:0];
      endcase
    end
  end

  // controller state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= msp_pkg::RUN_STOP;
      enable         <= 1'b0;
      target_reg     <= '0;
      integral       <= '0;
      move_cnt       <= '0;
      move_len       <= '0;
      rev_cnt        <= '0;
      stall          <= '0;
      latest_current <= '0;
      duty_a_reg     <= '0;
      duty_b_reg     <= '0;
      out_valid      <= 1'b0;
    end else begin
      unique case (state)
        msp_pkg::ST_PRE: begin
          if (action_in == msp_pkg::ACT_CMD) begin
            // speed command: ignore nonzero targets while reversing
            if (!(mode == msp_pkg::RUN_BACKOFF && target_in != 16'sd0)) begin
              if (target_in == 16'sd0) begin
                target_reg <= '0;
                enable     <= 1'b0;
                mode       <= msp_pkg::RUN_STOP;
              end else begin
                target_reg <= target_in;
                if (!enable || mode == msp_pkg::RUN_STOP) begin
                  move_cnt <= '0;
                  mode     <= msp_pkg::RUN_DRIVE;
                end
                enable <= 1'b1;
              end
            end
          end else begin
            if (cur_valid_in) begin
              latest_current <= cur_abs;
            end
            if (!enable) begin
              integral   <= '0;
              stall      <= '0;
              duty_a_reg <= '0;
              duty_b_reg <= '0;
            end else if (mode == msp_pkg::RUN_DRIVE) begin
              move_cnt <= move_inc;
              // overcurrent: flip the target and reverse for the move length
              if (trip) begin
                move_len   <= move_inc;
                mode       <= msp_pkg::RUN_BACKOFF;
                target_reg <= tgt_neg;
                rev_cnt    <= '0;
                integral   <= '0;
              end
            end else if (mode == msp_pkg::RUN_BACKOFF) begin
              rev_cnt <= rev_inc;
              if (rev_done) begin
                target_reg <= '0;
                enable     <= 1'b0;
                mode       <= msp_pkg::RUN_STOP;
                integral   <= '0;
                duty_a_reg <= '0;
                duty_b_reg <= '0;
              end
            end
          end
        end
        msp_pkg::ST_PROP: begin
          integral <= acc_c;
        end
        msp_pkg::ST_DRV: begin
          if (stall_cond) begin
            stall <= stall_inc;
          end else begin
            stall <= '0;
          end
          if (stall_cond && stall_stop) begin
            target_reg <= '0;
            enable     <= 1'b0;
            mode       <= msp_pkg::RUN_STOP;
            integral   <= '0;
            duty_a_reg <= '0;
            duty_b_reg <= '0;
          end else if (ctl[35]) begin
            duty_a_reg <= '0;
            duty_b_reg <= duty;
          end else begin
            duty_a_reg <= duty;
            duty_b_reg <= '0;
          end
        end
        default: begin
        end
      endcase
      // output register handshake
      if (state == msp_pkg::ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item latch, datapath and result payload
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_fire) begin
      action_in    <= s_axis_tuser[0];
      cur_valid_in <= s_axis_tuser[1];
      delta_in     <= s_axis_tdata[15:0];
      cur_raw_in   <= s_axis_tdata[31:16];
      target_in    <= s_axis_tdata[47:32];
    end
    unique case (state)
      msp_pkg::ST_PRE:  event_r <= pre_event;
      msp_pkg::ST_TGT:  meas    <= prod[31:0];
      msp_pkg::ST_ERR:  err     <= err_next;
      msp_pkg::ST_INT:  ctl     <= {sh[34], sh};
      msp_pkg::ST_PROP: ctl     <= ctl + {{17{acc_c[18]}}, acc_c};
      msp_pkg::ST_FIN:  ctl     <= ctl_clamp;
      msp_pkg::ST_DRV: begin
        if (stall_cond && stall_stop) begin
          event_r <= msp_pkg::EV_STALL;
        end
      end
      default: begin
      end
    endcase
    if (state == msp_pkg::ST_OUT && out_free) begin
      out_duty_a <= duty_a_reg;
      out_duty_b <= duty_b_reg;
      out_mode   <= mode;
      out_enable <= enable;
      out_event  <= event_r;
    end
  end

endmodule

// ----- bench/motor_speed_pi_autoreverse_tb.sv -----
`timescale 1ns / 100ps
// Testbench for motor_speed_pi_autoreverse: streams command and tick items,
// predicts each result from its own model of the controller and checks it.
// Depends on msp_pkg and the controller RTL.
module motor_speed_pi_autoreverse_tb;

  typedef struct packed {
    logic [9:0]     duty_a;
    logic [9:0]     duty_b;
    msp_pkg::mode_t run_mode;
    logic           drive_on;
    msp_pkg::evt_t  event_code;
  } bridge_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [15:0] encoder_delta, [31:16] current_raw, [47:32] shaft_speed
  logic [47:0] s_axis_tdata;
  // [0] action, [1] current_valid
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [9:0] duty_a, [19:10] duty_b, [21:20] run_mode, [22] drive_on, [24:23] event_code
  logic [31:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  motor_speed_pi_autoreverse uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Controller model state and gain registers
  int unsigned       gain_defaults [8];
  int unsigned       gain_regs [8];
  msp_pkg::mode_t    ctl_mode = msp_pkg::RUN_STOP;
  bit                drive_enabled = 1'b0;
  logic signed [15:0] target_q8 = '0;
  longint            integ_q8 = 0;
  int                run_ticks = 0;
  int                run_length = 0;
  int                back_ticks = 0;
  int                stall_count = 0;
  longint            shunt_mag = 0;
  logic [9:0]        leg_a = '0;
  logic [9:0]        leg_b = '0;

  bridge_result_t pending_results[$];
  bridge_result_t oldest_result;
  int err_count;
  int items_sent;
  int results_seen;
  bit gaps_on;
  bit stalls_on;
  int stall_hold;

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("motor_speed_pi_autoreverse_tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, got, want));
  endtask

  function automatic longint mag64(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Stop the drive; on a reverse end or stall also clear the loop and legs
  function automatic void halt_drive(bit wipe);
    target_q8 = '0;
    drive_enabled = 1'b0;
    ctl_mode = msp_pkg::RUN_STOP;
    if (wipe) begin
      integ_q8 = 0;
      leg_a = '0;
      leg_b = '0;
    end
  endfunction

  // Apply min duty, limit, round and pick the bridge leg
  function automatic void steer_legs(longint out);
    longint mag;
    longint duty;
    longint floor_q8;
    mag = mag64(out);
    floor_q8 = longint'(gain_regs[msp_pkg::REG_MIN_DUTY]) * 256;
    if (mag > msp_pkg::MIN_DUTY_FLOOR && mag < floor_q8)
      mag = floor_q8;
    if (mag > msp_pkg::DUTY_MAX_DEF * 256)
      mag = msp_pkg::DUTY_MAX_DEF * 256;
    duty = (mag + 128) >>> 8;
    if (duty > msp_pkg::LEG_MAX)
      duty = msp_pkg::LEG_MAX;
    if (out >= 0) begin
      leg_a = duty[9:0];
      leg_b = '0;
    end else begin
      leg_a = '0;
      leg_b = duty[9:0];
    end
  endfunction

  // Advance the controller model by one item and return its result
  function automatic bridge_result_t predict_motor_step(logic act,
      logic signed [15:0] delta, logic signed [15:0] cur, logic cur_ok,
      logic signed [15:0] tgt);
    bridge_result_t res;
    msp_pkg::evt_t ev;
    longint meas, tgt_motor, err, acc, lim, ctl, cap;
    bit     ran;
    ev = msp_pkg::EV_NONE;
    if (act == msp_pkg::ACT_CMD) begin
      if (!(ctl_mode == msp_pkg::RUN_BACKOFF && tgt != 0)) begin
        if (tgt == 0) begin
          halt_drive(1'b0);
        end else begin
          target_q8 = tgt;
          if (!drive_enabled || ctl_mode == msp_pkg::RUN_STOP) begin
            run_ticks = 0;
            ctl_mode = msp_pkg::RUN_DRIVE;
          end
          drive_enabled = 1'b1;
        end
      end
    end else begin
      ran = 1'b1;
      if (cur_ok)
        shunt_mag = mag64(longint'(cur));
      meas = longint'(delta) * longint'(gain_regs[msp_pkg::REG_RPM_PER_COUNT]);
      if (!drive_enabled) begin
        integ_q8 = 0;
        stall_count = 0;
        leg_a = '0;
        leg_b = '0;
        ran = 1'b0;
      end else if (ctl_mode == msp_pkg::RUN_DRIVE) begin
        if (run_ticks < 65535)
          run_ticks++;
        // Trip: flip the target and back off for the length of the move
        if (shunt_mag > longint'(gain_regs[msp_pkg::REG_CURRENT_LIMIT])) begin
          ev = msp_pkg::EV_TRIP;
          run_length = run_ticks;
          ctl_mode = msp_pkg::RUN_BACKOFF;
          target_q8 = (target_q8 == 16'sh8000) ? 16'sh7FFF : -target_q8;
          back_ticks = 0;
          integ_q8 = 0;
        end
      end else if (ctl_mode == msp_pkg::RUN_BACKOFF) begin
        if (back_ticks < 65535)
          back_ticks++;
        if (back_ticks >= run_length) begin
          halt_drive(1'b1);
          ev = msp_pkg::EV_REV_DONE;
          ran = 1'b0;
        end
      end

      if (ran) begin
        tgt_motor = longint'(target_q8) * longint'(gain_regs[msp_pkg::REG_GEAR_DIV]);
        err = tgt_motor - meas;
        lim = longint'(gain_regs[msp_pkg::REG_INTEG_CLAMP]);
        acc = integ_q8
            + ((err * longint'(gain_regs[msp_pkg::REG_INTEG_GAIN_DT])) >>> 16);
        if (acc > lim)
          acc = lim;
        if (acc < -lim)
          acc = -lim;
        integ_q8 = acc;
        ctl = ((tgt_motor * longint'(gain_regs[msp_pkg::REG_FF_GAIN])) >>> 16)
            + ((err * longint'(gain_regs[msp_pkg::REG_PROP_GAIN])) >>> 16) + acc;
        cap = msp_pkg::DUTY_MAX_DEF * 256;
        if (ctl > cap)
          ctl = cap;
        if (ctl < -cap)
          ctl = -cap;
        // Count ticks of heavy drive with the shaft nearly still
        if (mag64(ctl) * 5 > cap && mag64(meas) < 256) begin
          stall_count++;
          if (stall_count > msp_pkg::STALL_LIMIT_DEF) begin
            halt_drive(1'b1);
            ev = msp_pkg::EV_STALL;
            ran = 1'b0;
          end
        end else begin
          stall_count = 0;
        end
        if (ran)
          steer_legs(ctl);
      end
    end
    res.duty_a = leg_a;
    res.duty_b = leg_b;
    res.run_mode = ctl_mode;
    res.drive_on = drive_enabled;
    res.event_code = ev;
    return res;
  endfunction

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_idle_len(bit enabled);
    int r;
    if (!enabled)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one item and record its expected result once accepted
  task automatic send_item(logic act, logic [15:0] delta, logic [15:0] cur,
                           logic cur_ok, logic [15:0] tgt);
    int gap;
    gap = pick_idle_len(gaps_on);
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk);
    s_axis_tdata = {tgt, cur, delta};
    s_axis_tuser = {cur_ok, act};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_motor_step(act, delta, cur, cur_ok, tgt));
    items_sent++;
  endtask

  task automatic send_tick(logic [15:0] delta, logic [15:0] cur, logic cur_ok);
    send_item(msp_pkg::ACT_TICK, delta, cur, cur_ok, 16'($urandom));
  endtask

  task automatic send_cmd(logic [15:0] tgt);
    send_item(msp_pkg::ACT_CMD, 16'($urandom), 16'($urandom), 1'($urandom), tgt);
  endtask

  // Drop valid, wait for every expected result, then let the block go quiet
  task automatic settle();
    int waited;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      pending_results.delete();
    end
    repeat (12) @(posedge clk);
  endtask

  // Write all gain registers while idle and read each one back
  task automatic program_gains(input int unsigned vals [8]);
    settle();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = 5'(i * 4);
      pwdata = vals[i];
      @(negedge clk);
      penable = 1'b1;
      do @(posedge clk); while (!pready);
      gain_regs[i] = vals[i];
      @(negedge clk);
      pwrite = 1'b0;
      penable = 1'b0;
      @(negedge clk);
      penable = 1'b1;
      do @(posedge clk); while (!pready);
      check_field($sformatf("register %0d readback", i), prdata, gain_regs[i]);
      @(negedge clk);
      psel = 1'b0;
      penable = 1'b0;
    end
  endtask

  function automatic logic [15:0] rand_delta();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4)
      return 16'h0000;
    if (r < 8)
      return 16'($urandom_range(0, 16) - 8);
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_target();
    int r;
    logic [15:0] m;
    r = $urandom_range(0, 9);
    if (r < 5)
      m = 16'($urandom_range(1, 3000));
    else if (r < 8)
      m = 16'($urandom_range(1, 12000));
    else
      return 16'($urandom);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  // Shunt sample under the trip level, or above it when over is set
  function automatic logic [15:0] rand_current(bit over);
    int unsigned lim, mag;
    logic [15:0] m16;
    lim = gain_regs[msp_pkg::REG_CURRENT_LIMIT];
    if (over)
      mag = (lim >= 32767) ? 32768 : $urandom_range(lim + 1, 32768);
    else
      mag = $urandom_range(0, lim);
    if (mag == 32768)
      return 16'h8000;
    m16 = mag[15:0];
    return $urandom_range(0, 1) ? -m16 : m16;
  endfunction

  // One move: command, ticks, then maybe a trip and the reverse that follows
  task automatic run_move(int max_ticks, int trip_pct);
    int n;
    logic [15:0] t;
    t = rand_target();
    if (t == 16'h0000)
      t = 16'h0001;
    send_cmd(t);
    n = $urandom_range(1, max_ticks);
    repeat (n) begin
      if ($urandom_range(0, 29) == 0)
        send_cmd(rand_target());
      send_tick(rand_delta(), rand_current(1'b0), $urandom_range(0, 7) != 0);
    end
    if ($urandom_range(0, 99) < trip_pct) begin
      send_tick(rand_delta(), rand_current(1'b1), 1'b1);
      repeat (n + 2) begin
        if ($urandom_range(0, 9) == 0)
          send_cmd(rand_target());
        else if ($urandom_range(0, 39) == 0)
          send_cmd(16'h0000);
        send_tick(rand_delta(), rand_current(1'b0), $urandom_range(0, 3) != 0);
      end
    end else if ($urandom_range(0, 1) == 1) begin
      send_cmd(16'h0000);
    end
  endtask

  // Hand-picked items for the corner cases of the controller
  task automatic test_directed_cases();
    // ticks while disabled, field extremes, largest shunt magnitude
    send_tick(16'h7FFF, 16'h8000, 1'b1);
    send_tick(16'h8000, 16'h0010, 1'b0);   // invalid sample keeps the held current
    send_cmd(16'h0000);                    // stop while idle
    send_cmd(16'h8000);                    // most negative target
    send_tick(16'h0000, 16'h0000, 1'b0);   // trip on held current, target saturates
    send_cmd(16'd1000);                    // ignored while reversing
    send_tick(16'h0000, 16'h0000, 1'b1);   // reverse ends after one tick
    // tiny targets hit the min duty on either leg
    send_cmd(16'd2);
    send_tick(16'h0000, 16'd50, 1'b1);
    send_tick(16'h0000, 16'hFFCE, 1'b1);
    send_cmd(16'hFFFE);
    send_tick(16'h0000, 16'h0000, 1'b1);
    // runaway encoder readings saturate the duty both ways
    send_tick(16'h7FFF, 16'h0000, 1'b1);
    send_tick(16'h8000, 16'h0000, 1'b1);
    send_cmd(16'h7FFF);
    send_tick(16'h0001, 16'h0000, 1'b1);
    send_tick(16'h0000, 16'h7FFF, 1'b1);   // trip at full scale current
    send_tick(16'h0000, 16'h0000, 1'b1);
    send_cmd(16'h0000);                    // zero target stops a reverse
    send_tick(16'hFFFF, 16'h0000, 1'b1);
    settle();
  endtask

  // Heavy drive with a still shaft must end in a stall stop
  task automatic test_stall_stop();
    logic [15:0] t;
    repeat (3) begin
      t = 16'($urandom_range(8000, 32767));
      send_cmd($urandom_range(0, 1) ? -t : t);
      repeat (msp_pkg::STALL_LIMIT_DEF + 3)
        send_tick(16'h0000, rand_current(1'b0), 1'b1);
    end
    settle();
  endtask

  task automatic test_overcurrent_reverse();
    repeat (10)
      run_move(12, 100);
    settle();
  endtask

  // Gains at their extremes, at random, then back to reset values
  task automatic test_register_sweep();
    int unsigned v [8];
    v = '{65535, 1023, 65535, 65535, 65535, 261888, 32767, 1023};
    program_gains(v);
    repeat (4)
      run_move(8, 40);
    v = '{0, 1, 0, 0, 0, 0, 0, 0};
    program_gains(v);
    repeat (4)
      run_move(8, 40);
    repeat (3) begin
      v[msp_pkg::REG_RPM_PER_COUNT] = $urandom_range(0, 65535);
      v[msp_pkg::REG_GEAR_DIV]      = $urandom_range(1, 1023);
      v[msp_pkg::REG_FF_GAIN]       = $urandom_range(0, 65535);
      v[msp_pkg::REG_PROP_GAIN]     = $urandom_range(0, 65535);
      v[msp_pkg::REG_INTEG_GAIN_DT] = $urandom_range(0, 65535);
      v[msp_pkg::REG_INTEG_CLAMP]   = $urandom_range(0, 261888);
      v[msp_pkg::REG_CURRENT_LIMIT] = $urandom_range(0, 32767);
      v[msp_pkg::REG_MIN_DUTY]      = $urandom_range(0, 1023);
      program_gains(v);
      repeat (4)
        run_move(10, 40);
    end
    program_gains(gain_defaults);
  endtask

  // Mostly well-formed moves with random content, some raw noise items
  task automatic test_random_traffic();
    int goal;
    goal = items_sent + 380;
    while (items_sent < goal) begin
      if ($urandom_range(0, 7) == 0) begin
        gaps_on = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 3) != 0) begin
        run_move(20, 30);
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                    16'($urandom));
      end
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold--;
      m_axis_tready = 1'b0;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      stall_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40)
                                               : $urandom_range(0, 2);
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with none expected", m_axis_tdata));
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("duty_a", m_axis_tdata[9:0], oldest_result.duty_a);
        check_field("duty_b", m_axis_tdata[19:10], oldest_result.duty_b);
        check_field("run_mode", m_axis_tdata[21:20], oldest_result.run_mode);
        check_field("drive_on", m_axis_tdata[22], oldest_result.drive_on);
        check_field("event_code", m_axis_tdata[24:23], oldest_result.event_code);
      end
      results_seen++;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_count = 0;
    items_sent = 0;
    results_seen = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    stall_hold = 0;
    gain_defaults[msp_pkg::REG_RPM_PER_COUNT] = msp_pkg::RST_RPM_PER_COUNT;
    gain_defaults[msp_pkg::REG_GEAR_DIV]      = msp_pkg::RST_GEAR_DIV;
    gain_defaults[msp_pkg::REG_FF_GAIN]       = msp_pkg::RST_FF_GAIN;
    gain_defaults[msp_pkg::REG_PROP_GAIN]     = msp_pkg::RST_PROP_GAIN;
    gain_defaults[msp_pkg::REG_INTEG_GAIN_DT] = msp_pkg::RST_INTEG_GAIN_DT;
    gain_defaults[msp_pkg::REG_INTEG_CLAMP]   = msp_pkg::RST_INTEG_CLAMP;
    gain_defaults[msp_pkg::REG_CURRENT_LIMIT] = msp_pkg::RST_CURRENT_LIMIT;
    gain_defaults[msp_pkg::REG_MIN_DUTY]      = msp_pkg::RST_MIN_DUTY;
    gain_regs = gain_defaults;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_stall_stop();
    test_overcurrent_reverse();
    test_register_sweep();
    test_random_traffic();
    settle();

    if (err_count == 0) begin
      $display("motor_speed_pi_autoreverse_tb: PASS");
    end else begin
      $display("motor_speed_pi_autoreverse_tb: FAIL");
    end
    $finish;
  end

endmodule
